/* rtl/ptw_pkg.sv */
// shared types, constants and helpers of the page table walker
package ptw_pkg;

    localparam int VA_W       = 48;
    localparam int FRAME_W    = 40;
    localparam int ENTRY_W    = 64;
    localparam int ADDR_W     = 52;
    localparam int IDX_W      = 9;
    localparam int ENTRY_SHIFT = 3;
    localparam int FRAME_LSB  = 12;
    localparam int PRESENT_BIT = 0;
    localparam int LARGE_BIT  = 7;

    localparam logic FUNC_TRANSLATE = 1'b0;
    localparam logic FUNC_ENTRY     = 1'b1;

    localparam logic [1:0] KIND_READ  = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_FAULT = 2'd2;

    localparam logic [1:0] LEVEL_PML4 = 2'd0;
    localparam logic [1:0] LEVEL_PDPT = 2'd1;
    localparam logic [1:0] LEVEL_PD   = 2'd2;
    localparam logic [1:0] LEVEL_PT   = 2'd3;

    // classified item; frame is the root frame for a request, entry bits 51:12 otherwise
    typedef struct packed {
        logic               is_req;
        logic               present;
        logic               large_page;
        logic [FRAME_W-1:0] frame;
        logic [VA_W-1:0]    virt_addr;
    } ptw_cmd_t;

    function automatic logic [IDX_W-1:0] table_index(input logic [VA_W-1:0] va,
                                                     input logic [1:0] level);
        logic [IDX_W-1:0] idx;
        begin
            unique case (level)
                LEVEL_PML4: idx = va[47:39];
                LEVEL_PDPT: idx = va[38:30];
                LEVEL_PD:   idx = va[29:21];
                LEVEL_PT:   idx = va[20:12];
                default:    idx = va[47:39];
            endcase
            return idx;
        end
    endfunction

endpackage

/* rtl/ptw_cmd_if.sv */
// input channel of the page table walker
interface ptw_cmd_if
    import ptw_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               func;
    logic [VA_W-1:0]    virt_addr;
    logic [FRAME_W-1:0] root_frame;
    logic [ENTRY_W-1:0] table_entry;

    modport source (output valid, output func, output virt_addr, output root_frame,
                    output table_entry, input ready);
    modport sink   (input valid, input func, input virt_addr, input root_frame,
                    input table_entry, output ready);
endinterface

/* rtl/ptw_rsp_if.sv */
// result channel of the page table walker
interface ptw_rsp_if
    import ptw_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [1:0]        kind;
    logic [ADDR_W-1:0] address;

    modport source (output valid, output kind, output address, input ready);
    modport sink   (input valid, input kind, input address, output ready);
endinterface

/* rtl/ptw_front.sv */
// front end: accepts transfers and classifies them into queue items
module ptw_front
    import ptw_pkg::*;
(
    ptw_cmd_if.sink  cmd,
    input  logic     queue_full,
    output logic     push,
    output ptw_cmd_t push_item
);

    assign cmd.ready = !queue_full;
    assign push      = cmd.valid && !queue_full;

    always_comb
    begin
        push_item.is_req     = (cmd.func == FUNC_TRANSLATE);
        push_item.present    = cmd.table_entry[PRESENT_BIT];
        push_item.large_page = cmd.table_entry[LARGE_BIT];
        push_item.virt_addr  = cmd.virt_addr;
        if (cmd.func == FUNC_TRANSLATE)
        begin
            push_item.frame = cmd.root_frame;
        end
        else
        begin
            push_item.frame = cmd.table_entry[FRAME_LSB +: FRAME_W];
        end
    end

endmodule

/* rtl/ptw_queue.sv */
// two-entry queue between front end and back end
module ptw_queue
    import ptw_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  ptw_cmd_t push_item,
    input  logic     pop,
    output logic     full,
    output logic     head_valid,
    output ptw_cmd_t head
);

    ptw_cmd_t   slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head       = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = !wr_ptr_reg;
        end
        if (pop)
        begin
            rd_ptr_next = !rd_ptr_reg;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

/* rtl/ptw_back.sv */
// back end: walk state, address forming and result register
module ptw_back
    import ptw_pkg::*;
#(
    parameter int PHYS_ADDR_BITS = 52
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     head_valid,
    input  ptw_cmd_t head,
    output logic     pop,
    ptw_rsp_if.source res
);

    logic                      busy_reg, busy_next;
    logic [1:0]                level_reg, level_next;
    logic [VA_W-1:0]           va_reg, va_next;
    logic                      out_valid_reg, out_valid_next;
    logic [1:0]                out_kind_reg, out_kind_next;
    logic [PHYS_ADDR_BITS-1:0] out_addr_reg, out_addr_next;

    logic              emit;
    logic [1:0]        emit_kind;
    logic [ADDR_W-1:0] full_addr;
    logic [1:0]        level_inc;

    assign pop       = head_valid && (!out_valid_reg || res.ready);
    assign level_inc = level_reg + 2'd1;

    // classify the head item against the walk state
    always_comb
    begin
        emit       = 1'b0;
        emit_kind  = KIND_READ;
        full_addr  = '0;
        busy_next  = busy_reg;
        level_next = level_reg;
        va_next    = va_reg;
        if (head.is_req)
        begin
            emit       = 1'b1;
            emit_kind  = KIND_READ;
            full_addr  = {head.frame, table_index(head.virt_addr, LEVEL_PML4),
                          {ENTRY_SHIFT{1'b0}}};
            busy_next  = 1'b1;
            level_next = LEVEL_PML4;
            va_next    = head.virt_addr;
        end
        else if (busy_reg)
        begin
            emit = 1'b1;
            if (!head.present)
            begin
                emit_kind = KIND_FAULT;
                busy_next = 1'b0;
            end
            else if (level_reg == LEVEL_PDPT && head.large_page)
            begin
                // 1 GiB page
                emit_kind = KIND_DONE;
                full_addr = {head.frame[FRAME_W-1:18], va_reg[29:0]};
                busy_next = 1'b0;
            end
            else if (level_reg == LEVEL_PD && head.large_page)
            begin
                // 2 MiB page
                emit_kind = KIND_DONE;
                full_addr = {head.frame[FRAME_W-1:9], va_reg[20:0]};
                busy_next = 1'b0;
            end
            else if (level_reg == LEVEL_PT)
            begin
                emit_kind = KIND_DONE;
                full_addr = {head.frame, va_reg[FRAME_LSB-1:0]};
                busy_next = 1'b0;
            end
            else
            begin
                emit_kind  = KIND_READ;
                full_addr  = {head.frame, table_index(va_reg, level_inc),
                              {ENTRY_SHIFT{1'b0}}};
                level_next = level_inc;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_kind_next  = out_kind_reg;
        out_addr_next  = out_addr_reg;
        if (pop)
        begin
            out_valid_next = emit;
            if (emit)
            begin
                out_kind_next = emit_kind;
                out_addr_next = full_addr[PHYS_ADDR_BITS-1:0];
            end
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            level_reg     <= LEVEL_PML4;
            va_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                busy_reg  <= busy_next;
                level_reg <= level_next;
                va_reg    <= va_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_kind_reg <= out_kind_next;
        out_addr_reg <= out_addr_next;
    end

    assign res.valid   = out_valid_reg;
    assign res.kind    = out_kind_reg;
    assign res.address = ADDR_W'(out_addr_reg);

endmodule

/* rtl/four_level_page_table_walker_top.sv */
// top level of the four-level page table walker
// Walks x86-64 four-level page tables one transfer at a time. A transfer on cmd with
// func clear starts (or restarts) a walk and is answered by a read request for the
// top-level entry; each transfer with func set carries the entry read from memory and
// is answered by the next read request, the translated physical address, or a fault
// with address 0. Entries that arrive while no walk is active give no result. The
// front end classifies each transfer and puts it in a two-entry queue; the back end
// holds the walk state (active flag, level, virtual address) and retires one queued
// item per cycle into the result register, so one item per cycle is sustained while
// res takes results. With an empty queue an item goes into the queue at the cmd
// transfer and from there into the result register, which drives res valid. A stalled
// res holds one result and lets the queue fill; cmd ready drops once two items wait.
// All produced addresses are truncated to PHYS_ADDR_BITS and zero-extended on res.
module four_level_page_table_walker_top
    import ptw_pkg::*;
#(
    parameter int PHYS_ADDR_BITS = 52
)
(
    input  logic      clk,
    input  logic      rst_n,
    ptw_cmd_if.sink   cmd,
    ptw_rsp_if.source res
);

    // front end to queue
    logic     push;
    ptw_cmd_t push_item;
    logic     queue_full;

    // queue to back end
    logic     head_valid;
    ptw_cmd_t head;
    logic     pop;

    ptw_front u_front (
        .cmd        (cmd),
        .queue_full (queue_full),
        .push       (push),
        .push_item  (push_item)
    );

    ptw_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .pop        (pop),
        .full       (queue_full),
        .head_valid (head_valid),
        .head       (head)
    );

    // back end owns the walk state and the result register
    ptw_back #(
        .PHYS_ADDR_BITS (PHYS_ADDR_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .res        (res)
    );

`ifndef NO_ASSERTIONS
    // a retired translate request always shows a read request next
    assert property (@(posedge clk) disable iff (!rst_n)
        pop && head.is_req |=> res.valid && res.kind == KIND_READ)
        else $error("translate request did not produce a read request");

    // a fault never carries an address
    assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.kind == KIND_FAULT |-> res.address == '0)
        else $error("fault result with nonzero address");

    // the queue never takes a transfer when full
    assert property (@(posedge clk) disable iff (!rst_n)
        queue_full |-> !push)
        else $error("push into full queue");
`endif

endmodule

/* tb/tb_four_level_page_table_walker_top.sv */
// self-checking testbench of the four-level page table walker top level
`timescale 1ns / 1ps

module tb_four_level_page_table_walker_top;
    import ptw_pkg::*;

    // one result of the walker as seen on res
    typedef struct packed {
        logic [1:0]        kind;
        logic [ADDR_W-1:0] address;
    } walk_result_t;

    // one transfer on cmd, with an optional hand-typed expectation
    typedef struct {
        logic               func;
        logic [VA_W-1:0]    virt_addr;
        logic [FRAME_W-1:0] root_frame;
        logic [ENTRY_W-1:0] table_entry;
        bit                 typed;
        bit                 typed_has;
        walk_result_t       typed_res;
    } walk_item_t;

    logic clk;
    logic rst_n;

    ptw_cmd_if cmd_ch ();
    ptw_rsp_if res_ch ();

    four_level_page_table_walker_top dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .res   (res_ch)
    );

    // walk state mirrored from the incoming transfers
    bit              walk_active;
    logic [1:0]      walk_level;
    logic [VA_W-1:0] walk_va;

    walk_result_t expected_walk_results[$];
    walk_item_t   dir_rows[$];
    walk_item_t   cur_item;

    int src_idle_pct;
    int snk_idle_pct;
    int err_cnt;
    int cnt_items;
    int cnt_read;
    int cnt_done;
    int cnt_fault;
    int cnt_ignored;
    int cnt_restart;

    // free-running clock, 10 ns period
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // nine-bit table index of a level: va bits 47:39, 38:30, 29:21, 20:12
    function automatic logic [IDX_W-1:0] entry_index(input logic [VA_W-1:0] va,
                                                     input logic [1:0] lvl);
        logic [VA_W-1:0] shifted;
        shifted = va >> (39 - 9 * int'(lvl));
        return shifted[IDX_W-1:0];
    endfunction

    // advances the mirrored walk state by one transfer and gives the result it causes
    function automatic void predict_walk(input logic f, input logic [VA_W-1:0] va,
                                         input logic [FRAME_W-1:0] root,
                                         input logic [ENTRY_W-1:0] e,
                                         output bit has_res, output walk_result_t r);
        logic [63:0] sum;
        logic [63:0] frame_addr;
        has_res    = 1'b1;
        sum        = 64'd0;
        r.kind     = KIND_READ;
        frame_addr = e & 64'h000F_FFFF_FFFF_F000;
        if (f == FUNC_TRANSLATE)
        begin
            // a request always restarts at the top level
            walk_va     = va;
            walk_level  = LEVEL_PML4;
            walk_active = 1'b1;
            sum = ({24'd0, root} << FRAME_LSB)
                + (64'(entry_index(va, LEVEL_PML4)) << ENTRY_SHIFT);
        end
        else if (!walk_active)
        begin
            // entry with no walk in flight is dropped
            has_res = 1'b0;
        end
        else if (!e[PRESENT_BIT])
        begin
            walk_active = 1'b0;
            r.kind      = KIND_FAULT;
        end
        else if (walk_level == LEVEL_PDPT && e[LARGE_BIT])
        begin
            // 1 GiB page
            walk_active = 1'b0;
            r.kind      = KIND_DONE;
            sum = (e & 64'h000F_FFFF_C000_0000) + {34'd0, walk_va[29:0]};
        end
        else if (walk_level == LEVEL_PD && e[LARGE_BIT])
        begin
            // 2 MiB page
            walk_active = 1'b0;
            r.kind      = KIND_DONE;
            sum = (e & 64'h000F_FFFF_FFE0_0000) + {43'd0, walk_va[20:0]};
        end
        else if (walk_level == LEVEL_PT)
        begin
            // 4 KiB page, bit 7 is pat here
            walk_active = 1'b0;
            r.kind      = KIND_DONE;
            sum = frame_addr + {52'd0, walk_va[11:0]};
        end
        else
        begin
            walk_level = walk_level + 2'd1;
            sum = frame_addr + (64'(entry_index(walk_va, walk_level)) << ENTRY_SHIFT);
        end
        r.address = sum[ADDR_W-1:0];
    endfunction

    function automatic walk_item_t mk_row(input logic f, input logic [VA_W-1:0] va,
                                          input logic [FRAME_W-1:0] root,
                                          input logic [ENTRY_W-1:0] e, input bit typed,
                                          input bit has, input logic [1:0] k,
                                          input logic [ADDR_W-1:0] a);
        walk_item_t it;
        it.func                = f;
        it.virt_addr           = va;
        it.root_frame          = root;
        it.table_entry         = e;
        it.typed               = typed;
        it.typed_has           = has;
        it.typed_res.kind      = k;
        it.typed_res.address   = a;
        return it;
    endfunction

    // presents one item, with random sender gaps, and returns after its transfer
    task automatic send_item(input walk_item_t it);
        while ($urandom_range(99) < src_idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            @(negedge clk);
        end
        cur_item = it;
        cmd_ch.valid       <= 1'b1;
        cmd_ch.func        <= it.func;
        cmd_ch.virt_addr   <= it.virt_addr;
        cmd_ch.root_frame  <= it.root_frame;
        cmd_ch.table_entry <= it.table_entry;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        @(negedge clk);
    endtask

    // random item of a given func; counts it unless the block will drop it
    task automatic send_random(input logic f, inout int sent);
        walk_item_t it;
        logic [ENTRY_W-1:0] e;
        e = {$urandom, $urandom};
        e[PRESENT_BIT] = ($urandom_range(99) < 93);
        it = mk_row(f, {16'($urandom_range(16'hFFFF)), 32'($urandom)},
                    {8'($urandom_range(8'hFF)), 32'($urandom)}, e,
                    1'b0, 1'b0, KIND_READ, '0);
        if (!(f == FUNC_ENTRY && !walk_active))
            sent++;
        send_item(it);
    endtask

    // mostly complete walks with random entries, the rest noise and cut-off walks
    task automatic run_random(input int n_target);
        int sent;
        int pick;
        int steps;
        sent = 0;
        while (sent < n_target)
        begin
            pick = $urandom_range(99);
            if (pick < 80)
            begin
                send_random(FUNC_TRANSLATE, sent);
                while (walk_active)
                begin
                    if ($urandom_range(99) < 4)
                        send_random(FUNC_TRANSLATE, sent);
                    else
                        send_random(FUNC_ENTRY, sent);
                end
            end
            else if (pick < 90)
            begin
                send_random(FUNC_ENTRY, sent);
            end
            else
            begin
                steps = $urandom_range(3, 1);
                repeat (steps)
                    send_random(1'($urandom_range(1)), sent);
            end
        end
    endtask

    // holds the sender off until every pending result has been taken
    task automatic wait_drained();
        cmd_ch.valid <= 1'b0;
        while (expected_walk_results.size() != 0)
            @(negedge clk);
        repeat (3)
            @(negedge clk);
    endtask

    // receiver stalls
    always @(negedge clk)
    begin
        res_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    // prediction at each cmd transfer, checking at each res transfer
    always @(posedge clk)
    begin
        bit           has;
        walk_result_t pred;
        walk_result_t want;
        if (cmd_ch.valid && cmd_ch.ready)
        begin
            cnt_items++;
            if (cmd_ch.func == FUNC_TRANSLATE && walk_active)
                cnt_restart++;
            predict_walk(cmd_ch.func, cmd_ch.virt_addr, cmd_ch.root_frame,
                         cmd_ch.table_entry, has, pred);
            if (cur_item.typed)
            begin
                has  = cur_item.typed_has;
                pred = cur_item.typed_res;
            end
            if (has)
                expected_walk_results.push_back(pred);
            else
                cnt_ignored++;
        end
        if (res_ch.valid && res_ch.ready)
        begin
            if (expected_walk_results.size() == 0)
            begin
                $display("%0t: unexpected result kind %0d address %h", $time,
                         res_ch.kind, res_ch.address);
                err_cnt++;
            end
            else
            begin
                want = expected_walk_results.pop_front();
                if (res_ch.kind !== want.kind)
                begin
                    $display("%0t: kind mismatch, expected %0d actual %0d", $time,
                             want.kind, res_ch.kind);
                    err_cnt++;
                end
                if (res_ch.address !== want.address)
                begin
                    $display("%0t: address mismatch, expected %h actual %h", $time,
                             want.address, res_ch.address);
                    err_cnt++;
                end
                case (want.kind)
                    KIND_READ:  cnt_read++;
                    KIND_DONE:  cnt_done++;
                    KIND_FAULT: cnt_fault++;
                    default:    ;
                endcase
            end
        end
    end

    // run limit, far above the slowest legal run
    initial
    begin
        #2_000_000;
        $display("four_level_page_table_walker_top test failed");
        $finish;
    end

    initial
    begin
        rst_n              = 1'b0;
        cmd_ch.valid       = 1'b0;
        cmd_ch.func        = FUNC_TRANSLATE;
        cmd_ch.virt_addr   = '0;
        cmd_ch.root_frame  = '0;
        cmd_ch.table_entry = '0;
        res_ch.ready       = 1'b0;
        walk_active        = 1'b0;
        walk_level         = LEVEL_PML4;
        walk_va            = '0;
        cur_item           = mk_row(FUNC_TRANSLATE, '0, '0, '0, 1'b0, 1'b0, KIND_READ, '0);
        err_cnt            = 0;
        cnt_items          = 0;
        cnt_read           = 0;
        cnt_done           = 0;
        cnt_fault          = 0;
        cnt_ignored        = 0;
        cnt_restart        = 0;
        src_idle_pct       = 15;
        snk_idle_pct       = 50;

        // directed rows: typed expectations only where they are obvious
        // entry right after reset, no walk yet, so nothing comes back
        dir_rows.push_back(mk_row(FUNC_ENTRY, '0, '0, '1, 1'b1, 1'b0, KIND_READ, '0));
        // all-zero request and a missing top-level entry
        dir_rows.push_back(mk_row(FUNC_TRANSLATE, '0, '0, '0, 1'b1, 1'b1, KIND_READ, '0));
        dir_rows.push_back(mk_row(FUNC_ENTRY, '0, '0, '0, 1'b1, 1'b1, KIND_FAULT, '0));
        // all-ones request, bit 7 reserved at the top, then a 1 GiB page of all ones
        dir_rows.push_back(mk_row(FUNC_TRANSLATE, '1, '1, '0, 1'b1, 1'b1, KIND_READ,
                                  52'hF_FFFF_FFFF_FFF8));
        dir_rows.push_back(mk_row(FUNC_ENTRY, '0, '0, '1, 1'b0, 1'b0, KIND_READ, '0));
        dir_rows.push_back(mk_row(FUNC_ENTRY, '0, '0, '1, 1'b1, 1'b1, KIND_DONE,
                                  52'hF_FFFF_FFFF_FFFF));
        // walk is over, entry is dropped
        dir_rows.push_back(mk_row(FUNC_ENTRY, '0, '0, '1, 1'b1, 1'b0, KIND_READ, '0));
        // 2 MiB page, nx bit set on the way
        dir_rows.push_back(mk_row(FUNC_TRANSLATE, 48'h0123_4567_89AB, 40'h12_3456, '0,
                                  1'b0, 1'b0, KIND_READ, '0));
        dir_rows.push_back(mk_row(FUNC_ENTRY, '0, '0, 64'h0000_0000_0002_0003,
                                  1'b0, 1'b0, KIND_READ, '0));
        dir_rows.push_back(mk_row(FUNC_ENTRY, '0, '0, 64'h8000_0000_0003_0001,
                                  1'b0, 1'b0, KIND_READ, '0));
        dir_rows.push_back(mk_row(FUNC_ENTRY, '0, '0, 64'h0000_0000_0040_0081,
                                  1'b0, 1'b0, KIND_READ, '0));
        // full four-level walk, bit 7 at the last level is pat and not a page size
        dir_rows.push_back(mk_row(FUNC_TRANSLATE, 48'h7FFF_FFFF_FFFF, '0, '0,
                                  1'b0, 1'b0, KIND_READ, '0));
        dir_rows.push_back(mk_row(FUNC_ENTRY, '0, '0, 64'h0000_0000_0000_1001,
                                  1'b0, 1'b0, KIND_READ, '0));
        dir_rows.push_back(mk_row(FUNC_ENTRY, '0, '0, 64'h0000_0000_0000_2001,
                                  1'b0, 1'b0, KIND_READ, '0));
        dir_rows.push_back(mk_row(FUNC_ENTRY, '0, '0, 64'h0000_0000_0000_3001,
                                  1'b0, 1'b0, KIND_READ, '0));
        dir_rows.push_back(mk_row(FUNC_ENTRY, '0, '0, 64'h000F_FFFF_FFFF_F081,
                                  1'b1, 1'b1, KIND_DONE, 52'hF_FFFF_FFFF_FFFF));
        // bit 7 ignored at the top, then a missing second-level entry
        dir_rows.push_back(mk_row(FUNC_TRANSLATE, 48'h0000_4000_0000, '1, '0,
                                  1'b0, 1'b0, KIND_READ, '0));
        dir_rows.push_back(mk_row(FUNC_ENTRY, '0, '0, 64'h0000_0000_0000_5081,
                                  1'b0, 1'b0, KIND_READ, '0));
        dir_rows.push_back(mk_row(FUNC_ENTRY, '0, '0, 64'hFFFF_FFFF_FFFF_FFFE,
                                  1'b1, 1'b1, KIND_FAULT, '0));
        // request in the middle of a walk restarts it, then a missing last-level entry
        dir_rows.push_back(mk_row(FUNC_TRANSLATE, 48'h1111_2222_3333, 40'h5, '0,
                                  1'b0, 1'b0, KIND_READ, '0));
        dir_rows.push_back(mk_row(FUNC_ENTRY, '0, '0, 64'h0000_0000_0000_6001,
                                  1'b0, 1'b0, KIND_READ, '0));
        dir_rows.push_back(mk_row(FUNC_TRANSLATE, 48'hABCD_EF01_2345, 40'h6, '0,
                                  1'b0, 1'b0, KIND_READ, '0));
        dir_rows.push_back(mk_row(FUNC_ENTRY, '0, '0, 64'h0000_0000_0000_7001,
                                  1'b0, 1'b0, KIND_READ, '0));
        dir_rows.push_back(mk_row(FUNC_ENTRY, '0, '0, 64'h0000_0000_0000_8001,
                                  1'b0, 1'b0, KIND_READ, '0));
        dir_rows.push_back(mk_row(FUNC_ENTRY, '0, '0, 64'h0000_0000_0000_9001,
                                  1'b0, 1'b0, KIND_READ, '0));
        dir_rows.push_back(mk_row(FUNC_ENTRY, '0, '0, '0, 1'b1, 1'b1, KIND_FAULT, '0));

        repeat (9)
            @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
            send_item(dir_rows[i]);
        wait_drained();

        // random walks: fast sender with slow receiver, then the two swapped, then full rate
        run_random(475);
        wait_drained();
        src_idle_pct = 50;
        snk_idle_pct = 15;
        run_random(475);
        wait_drained();
        src_idle_pct = 0;
        snk_idle_pct = 0;
        run_random(475);
        cmd_ch.valid <= 1'b0;

        while (expected_walk_results.size() != 0)
            @(posedge clk);
        repeat (10)
            @(posedge clk);

        $display("covered %0d transfers: %0d read requests, %0d translations, %0d faults",
                 cnt_items, cnt_read, cnt_done, cnt_fault);
        $display("plus %0d dropped idle entries and %0d restarts of a walk in flight",
                 cnt_ignored, cnt_restart);
        if (err_cnt == 0)
            $display("four_level_page_table_walker_top test passed");
        else
            $display("four_level_page_table_walker_top test failed");
        $finish;
    end

endmodule

/* four_level_page_table_walker_top.f */
rtl/ptw_pkg.sv
rtl/ptw_cmd_if.sv
rtl/ptw_rsp_if.sv
rtl/ptw_front.sv
rtl/ptw_queue.sv
rtl/ptw_back.sv
rtl/four_level_page_table_walker_top.sv
tb/tb_four_level_page_table_walker_top.sv
